/* src/cau_pkg.sv */
// cau_pkg: shared types and codes of the complex arithmetic unit.
// Used by every module of the unit; depends on nothing.
`default_nettype none

package cau_pkg;

    // Port width of every operand and result part
    localparam int CAU_DATA_BITS = 32;

    // Default number format
    localparam int CAU_WORD_BITS = 32;
    localparam int CAU_FRAC_BITS = 16;

    // Operation codes
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_NEG = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    // Control word that travels with each transaction down the pipeline
    typedef struct packed {
        logic       valid;
        logic [2:0] mode;
        logic       equal;
    } cau_ctl_t;

endpackage

`default_nettype wire

/* src/complex_arith_unit.sv */
// complex_arith_unit: top level of the complex arithmetic unit.
// Depends on cau_pkg, cau_mult and cau_div.
//
// Usage:
//   Input channel: in_valid / in_stall with mode and operands a, b in
//   signed fixed point (low WORD_BITS bits of each port, FRAC_BITS of
//   fraction). Output channel: out_valid / out_stall with r_re, r_im,
//   equal and status. Each transaction yields exactly one result.
//   Pipeline stages: input register, two multiply/sum stages, one prepare
//   stage, one divider stage per quotient bit (WORD_BITS + 1 of them) and
//   the output register. The divider's bit-per-stage chain sets that depth.
//   Throughput is one transaction per cycle for every mode while the
//   receiver does not stall a held result.
//   Reset empties the pipeline; out_valid is low afterward.
//   While the receiver stalls a held result, the whole pipeline freezes
//   and in_stall is raised in the same cycle; nothing is lost or repeated.
`default_nettype none

module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int WORD_BITS = CAU_WORD_BITS,
    parameter int FRAC_BITS = CAU_FRAC_BITS
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [2:0]                      mode,
    input  wire logic signed [CAU_DATA_BITS-1:0] a_re,
    input  wire logic signed [CAU_DATA_BITS-1:0] a_im,
    input  wire logic signed [CAU_DATA_BITS-1:0] b_re,
    input  wire logic signed [CAU_DATA_BITS-1:0] b_im,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic signed [CAU_DATA_BITS-1:0]      r_re,
    output logic signed [CAU_DATA_BITS-1:0]      r_im,
    output logic                                 equal,
    output logic [1:0]                           status
);

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;
    localparam int Q  = W + 1;
    localparam int RW = 2 * W + 1;
    localparam int XW = 2 * W + F;
    localparam int PB = 2 * W + 6;

    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    logic ce;

    // Input stage
    cau_ctl_t              s1_ctl_reg, s1_ctl_next;
    logic signed [W-1:0]   s1_a_re_reg, s1_a_im_reg, s1_b_re_reg, s1_b_im_reg;

    // Product and sum section
    cau_ctl_t              m_ctl;
    logic signed [W:0]     m_lin_re, m_lin_im;
    logic signed [SW-1:0]  m_mre, m_mim, m_dre, m_dim;
    logic [PW-1:0]         m_dsq;

    // Prepare stage
    logic signed [SW-1:0]  fr_re, fr_im, neg_dre, neg_dim;
    logic                  fit_re, fit_im;
    logic [W-1:0]          pre_re_next, pre_im_next;
    logic                  pre_sat_next;
    logic [PW-1:0]         mag_re, mag_im;
    logic [XW-1:0]         x_re, x_im, xq_re, xq_im;
    logic                  ovf_re_next, ovf_im_next, dz_next;
    logic [PB-1:0]         pass_next;
    cau_ctl_t              prep_ctl_reg;
    logic [PB-1:0]         prep_pass_reg;
    logic [RW-1:0]         prep_r0_re_reg, prep_r0_im_reg;
    logic [Q-1:0]          prep_xl_re_reg, prep_xl_im_reg;
    logic [PW-1:0]         prep_d_reg;

    // Divider outputs and final stage
    cau_ctl_t              dv_ctl;
    logic [PB-1:0]         dv_pass;
    logic [Q-1:0]          dv_q_re, dv_q_im;
    logic [W-1:0]          dv_pre_re, dv_pre_im;
    logic                  dv_pre_sat, dv_dz, dv_neg_re, dv_neg_im, dv_ovf_re, dv_ovf_im;
    logic [W-1:0]          qv_re, qv_im;
    logic                  qs_re, qs_im;
    logic                  out_valid_reg;
    logic [W-1:0]          r_re_reg, r_im_reg, r_re_next, r_im_next;
    logic                  equal_reg;
    logic [1:0]            status_reg, status_next;

    // Advance the pipeline unless a held result is stalled
    assign ce       = !out_valid_reg || !out_stall;
    assign in_stall = !ce;

    // Capture the transaction and compare operands
    always_comb
    begin
        s1_ctl_next.valid = in_valid;
        s1_ctl_next.mode  = mode;
        s1_ctl_next.equal = (a_re[W-1:0] == b_re[W-1:0]) && (a_im[W-1:0] == b_im[W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (ce)
        begin
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            s1_a_re_reg <= a_re[W-1:0];
            s1_a_im_reg <= a_im[W-1:0];
            s1_b_re_reg <= b_re[W-1:0];
            s1_b_im_reg <= b_im[W-1:0];
        end
    end

    cau_mult #(
        .W (W)
    ) u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .ctl_in  (s1_ctl_reg),
        .a_re    (s1_a_re_reg),
        .a_im    (s1_a_im_reg),
        .b_re    (s1_b_re_reg),
        .b_im    (s1_b_im_reg),
        .ctl_out (m_ctl),
        .lin_re  (m_lin_re),
        .lin_im  (m_lin_im),
        .mre     (m_mre),
        .mim     (m_mim),
        .dre     (m_dre),
        .dim     (m_dim),
        .dsq     (m_dsq)
    );

    // Finish the non-divide modes with saturation
    always_comb
    begin
        fr_re = m_mre >>> F;
        fr_im = m_mim >>> F;
        case (m_ctl.mode)
            MODE_ADD, MODE_SUB, MODE_NEG:
            begin
                fit_re      = m_lin_re[W] == m_lin_re[W-1];
                fit_im      = m_lin_im[W] == m_lin_im[W-1];
                pre_re_next = fit_re ? m_lin_re[W-1:0] : (m_lin_re[W] ? WMIN : WMAX);
                pre_im_next = fit_im ? m_lin_im[W-1:0] : (m_lin_im[W] ? WMIN : WMAX);
            end
            MODE_MUL:
            begin
                fit_re      = (&fr_re[SW-1:W-1]) || !(|fr_re[SW-1:W-1]);
                fit_im      = (&fr_im[SW-1:W-1]) || !(|fr_im[SW-1:W-1]);
                pre_re_next = fit_re ? fr_re[W-1:0] : (fr_re[SW-1] ? WMIN : WMAX);
                pre_im_next = fit_im ? fr_im[W-1:0] : (fr_im[SW-1] ? WMIN : WMAX);
            end
            default:
            begin
                fit_re      = 1'b1;
                fit_im      = 1'b1;
                pre_re_next = '0;
                pre_im_next = '0;
            end
        endcase
        pre_sat_next = !fit_re || !fit_im;
    end

    // Prepare the divider: magnitudes, scaled dividends, overflow check
    always_comb
    begin
        neg_dre     = -m_dre;
        neg_dim     = -m_dim;
        mag_re      = m_dre[SW-1] ? neg_dre[PW-1:0] : m_dre[PW-1:0];
        mag_im      = m_dim[SW-1] ? neg_dim[PW-1:0] : m_dim[PW-1:0];
        x_re        = XW'(mag_re) << F;
        x_im        = XW'(mag_im) << F;
        xq_re       = x_re >> Q;
        xq_im       = x_im >> Q;
        ovf_re_next = xq_re >= XW'(m_dsq);
        ovf_im_next = xq_im >= XW'(m_dsq);
        dz_next     = m_dsq == '0;
        pass_next   = {pre_re_next, pre_im_next, pre_sat_next, dz_next,
                       m_dre[SW-1], m_dim[SW-1], ovf_re_next, ovf_im_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_ctl_reg <= '0;
        end
        else if (ce)
        begin
            prep_ctl_reg <= m_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            prep_pass_reg  <= pass_next;
            prep_r0_re_reg <= RW'(xq_re);
            prep_r0_im_reg <= RW'(xq_im);
            prep_xl_re_reg <= x_re[Q-1:0];
            prep_xl_im_reg <= x_im[Q-1:0];
            prep_d_reg     <= m_dsq;
        end
    end

    cau_div #(
        .W  (W),
        .PB (PB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (ce),
        .ctl_in   (prep_ctl_reg),
        .pass_in  (prep_pass_reg),
        .r0_re    (prep_r0_re_reg),
        .r0_im    (prep_r0_im_reg),
        .xl_re    (prep_xl_re_reg),
        .xl_im    (prep_xl_im_reg),
        .d_in     (prep_d_reg),
        .ctl_out  (dv_ctl),
        .pass_out (dv_pass),
        .q_re     (dv_q_re),
        .q_im     (dv_q_im)
    );

    // Saturate quotients and pick the final result
    always_comb
    begin
        {dv_pre_re, dv_pre_im, dv_pre_sat, dv_dz,
         dv_neg_re, dv_neg_im, dv_ovf_re, dv_ovf_im} = dv_pass;

        if (dv_neg_re)
        begin
            qs_re = dv_ovf_re || dv_q_re[W] || (dv_q_re[W-1] && (|dv_q_re[W-2:0]));
            qv_re = qs_re ? WMIN : -dv_q_re[W-1:0];
        end
        else
        begin
            qs_re = dv_ovf_re || (|dv_q_re[W:W-1]);
            qv_re = qs_re ? WMAX : dv_q_re[W-1:0];
        end

        if (dv_neg_im)
        begin
            qs_im = dv_ovf_im || dv_q_im[W] || (dv_q_im[W-1] && (|dv_q_im[W-2:0]));
            qv_im = qs_im ? WMIN : -dv_q_im[W-1:0];
        end
        else
        begin
            qs_im = dv_ovf_im || (|dv_q_im[W:W-1]);
            qv_im = qs_im ? WMAX : dv_q_im[W-1:0];
        end

        if (dv_ctl.mode == MODE_DIV)
        begin
            if (dv_dz)
            begin
                r_re_next   = '0;
                r_im_next   = '0;
                status_next = ST_DZ;
            end
            else
            begin
                r_re_next   = qv_re;
                r_im_next   = qv_im;
                status_next = (qs_re || qs_im) ? ST_SAT : ST_OK;
            end
        end
        else
        begin
            r_re_next   = dv_pre_re;
            r_im_next   = dv_pre_im;
            status_next = dv_pre_sat ? ST_SAT : ST_OK;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            out_valid_reg <= dv_ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            r_re_reg   <= r_re_next;
            r_im_reg   <= r_im_next;
            equal_reg  <= dv_ctl.equal;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign r_re      = CAU_DATA_BITS'(signed'(r_re_reg));
    assign r_im      = CAU_DATA_BITS'(signed'(r_im_reg));
    assign equal     = equal_reg;
    assign status    = status_reg;

`ifndef NO_ASSERTIONS
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_SAT || status == ST_DZ))
        else $error("status code out of range");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_DZ) |-> (r_re == '0 && r_im == '0))
        else $error("divide by zero result not cleared");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(prep_ctl_reg))
        else $error("pipeline moved during a stall");
`endif

endmodule

`default_nettype wire

/* src/cau_mult.sv */
// cau_mult: two-stage product and sum section of the complex arithmetic unit.
// Depends on cau_pkg for the control word and operation codes.
`default_nettype none

module cau_mult
    import cau_pkg::*;
#(
    parameter int W = CAU_WORD_BITS
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                ce,
    input  wire cau_ctl_t            ctl_in,
    input  wire logic signed [W-1:0] a_re,
    input  wire logic signed [W-1:0] a_im,
    input  wire logic signed [W-1:0] b_re,
    input  wire logic signed [W-1:0] b_im,
    output cau_ctl_t                 ctl_out,
    output logic signed [W:0]        lin_re,
    output logic signed [W:0]        lin_im,
    output logic signed [2*W:0]      mre,
    output logic signed [2*W:0]      mim,
    output logic signed [2*W:0]      dre,
    output logic signed [2*W:0]      dim,
    output logic [2*W-1:0]           dsq
);

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 1;

    cau_ctl_t              ctl_a_reg;
    cau_ctl_t              ctl_b_reg;
    logic signed [PW-1:0]  p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, p_br_reg, p_bi_reg;
    logic signed [PW-1:0]  p_rr_next, p_ii_next, p_ri_next, p_ir_next, p_br_next, p_bi_next;
    logic signed [W:0]     lin_re_next, lin_im_next;
    logic signed [W:0]     lin_re_a_reg, lin_im_a_reg, lin_re_b_reg, lin_im_b_reg;
    logic signed [SW-1:0]  mre_next, mim_next, dre_next, dim_next;
    logic signed [SW-1:0]  mre_reg, mim_reg, dre_reg, dim_reg;
    logic [PW-1:0]         dsq_next, dsq_reg;

    // Form the six partial products
    always_comb
    begin
        p_rr_next = a_re * b_re;
        p_ii_next = a_im * b_im;
        p_ri_next = a_re * b_im;
        p_ir_next = a_im * b_re;
        p_br_next = b_re * b_re;
        p_bi_next = b_im * b_im;
    end

    // Form the unsaturated add, subtract and negate results
    always_comb
    begin
        case (ctl_in.mode)
            MODE_ADD:
            begin
                lin_re_next = {a_re[W-1], a_re} + {b_re[W-1], b_re};
                lin_im_next = {a_im[W-1], a_im} + {b_im[W-1], b_im};
            end
            MODE_SUB:
            begin
                lin_re_next = {a_re[W-1], a_re} - {b_re[W-1], b_re};
                lin_im_next = {a_im[W-1], a_im} - {b_im[W-1], b_im};
            end
            MODE_NEG:
            begin
                lin_re_next = -{a_re[W-1], a_re};
                lin_im_next = -{a_im[W-1], a_im};
            end
            default:
            begin
                lin_re_next = '0;
                lin_im_next = '0;
            end
        endcase
    end

    // Combine products into exact sums
    always_comb
    begin
        mre_next = {p_rr_reg[PW-1], p_rr_reg} - {p_ii_reg[PW-1], p_ii_reg};
        mim_next = {p_ri_reg[PW-1], p_ri_reg} + {p_ir_reg[PW-1], p_ir_reg};
        dre_next = {p_rr_reg[PW-1], p_rr_reg} + {p_ii_reg[PW-1], p_ii_reg};
        dim_next = {p_ir_reg[PW-1], p_ir_reg} - {p_ri_reg[PW-1], p_ri_reg};
        dsq_next = $unsigned(p_br_reg) + $unsigned(p_bi_reg);
    end

    // Advance control words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
        end
        else if (ce)
        begin
            ctl_a_reg <= ctl_in;
            ctl_b_reg <= ctl_a_reg;
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p_rr_reg     <= p_rr_next;
            p_ii_reg     <= p_ii_next;
            p_ri_reg     <= p_ri_next;
            p_ir_reg     <= p_ir_next;
            p_br_reg     <= p_br_next;
            p_bi_reg     <= p_bi_next;
            lin_re_a_reg <= lin_re_next;
            lin_im_a_reg <= lin_im_next;
            lin_re_b_reg <= lin_re_a_reg;
            lin_im_b_reg <= lin_im_a_reg;
            mre_reg      <= mre_next;
            mim_reg      <= mim_next;
            dre_reg      <= dre_next;
            dim_reg      <= dim_next;
            dsq_reg      <= dsq_next;
        end
    end

    assign ctl_out = ctl_b_reg;
    assign lin_re  = lin_re_b_reg;
    assign lin_im  = lin_im_b_reg;
    assign mre     = mre_reg;
    assign mim     = mim_reg;
    assign dre     = dre_reg;
    assign dim     = dim_reg;
    assign dsq     = dsq_reg;

endmodule

`default_nettype wire

/* src/cau_div.sv */
// cau_div: pipelined restoring divider, one quotient bit per stage, two
// numerators over a shared divisor. Depends on cau_pkg for the control word.
`default_nettype none

module cau_div
    import cau_pkg::*;
#(
    parameter int W  = CAU_WORD_BITS,
    parameter int PB = 2 * CAU_WORD_BITS + 6
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            ce,
    input  wire cau_ctl_t        ctl_in,
    input  wire logic [PB-1:0]   pass_in,
    input  wire logic [2*W:0]    r0_re,
    input  wire logic [2*W:0]    r0_im,
    input  wire logic [W:0]      xl_re,
    input  wire logic [W:0]      xl_im,
    input  wire logic [2*W-1:0]  d_in,
    output cau_ctl_t             ctl_out,
    output logic [PB-1:0]        pass_out,
    output logic [W:0]           q_re,
    output logic [W:0]           q_im
);

    localparam int Q  = W + 1;
    localparam int RW = 2 * W + 1;
    localparam int DW = 2 * W;

    cau_ctl_t        ctl_reg  [0:Q-1];
    logic [PB-1:0]   pass_reg [0:Q-1];
    logic [RW-1:0]   r_re_reg [0:Q-1];
    logic [RW-1:0]   r_im_reg [0:Q-1];
    logic [Q-1:0]    q_re_reg [0:Q-1];
    logic [Q-1:0]    q_im_reg [0:Q-1];
    logic [Q-1:0]    x_re_reg [0:Q-1];
    logic [Q-1:0]    x_im_reg [0:Q-1];
    logic [DW-1:0]   d_reg    [0:Q-1];

    for (genvar s = 0; s < Q; s++)
    begin : g_step
        cau_ctl_t       ctl_cur;
        logic [PB-1:0]  pass_cur;
        logic [RW-1:0]  r_re_cur, r_im_cur;
        logic [Q-1:0]   q_re_cur, q_im_cur, x_re_cur, x_im_cur;
        logic [DW-1:0]  d_cur;
        logic [RW-1:0]  sh_re, sh_im, r_re_next, r_im_next;
        logic           ge_re, ge_im;

        // Select this stage's source: the ports or the previous stage
        if (s == 0)
        begin : g_first
            assign ctl_cur  = ctl_in;
            assign pass_cur = pass_in;
            assign r_re_cur = r0_re;
            assign r_im_cur = r0_im;
            assign q_re_cur = '0;
            assign q_im_cur = '0;
            assign x_re_cur = xl_re;
            assign x_im_cur = xl_im;
            assign d_cur    = d_in;
        end
        else
        begin : g_next
            assign ctl_cur  = ctl_reg[s-1];
            assign pass_cur = pass_reg[s-1];
            assign r_re_cur = r_re_reg[s-1];
            assign r_im_cur = r_im_reg[s-1];
            assign q_re_cur = q_re_reg[s-1];
            assign q_im_cur = q_im_reg[s-1];
            assign x_re_cur = x_re_reg[s-1];
            assign x_im_cur = x_im_reg[s-1];
            assign d_cur    = d_reg[s-1];
        end

        // Shift in the next dividend bit and try one subtraction
        always_comb
        begin
            sh_re     = {r_re_cur[RW-2:0], x_re_cur[Q-1-s]};
            sh_im     = {r_im_cur[RW-2:0], x_im_cur[Q-1-s]};
            ge_re     = sh_re >= RW'(d_cur);
            ge_im     = sh_im >= RW'(d_cur);
            r_re_next = ge_re ? (sh_re - RW'(d_cur)) : sh_re;
            r_im_next = ge_im ? (sh_im - RW'(d_cur)) : sh_im;
        end

        // Advance control word
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[s] <= '0;
            end
            else if (ce)
            begin
                ctl_reg[s] <= ctl_cur;
            end
        end

        // Advance payload
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                pass_reg[s] <= pass_cur;
                r_re_reg[s] <= r_re_next;
                r_im_reg[s] <= r_im_next;
                q_re_reg[s] <= {q_re_cur[Q-2:0], ge_re};
                q_im_reg[s] <= {q_im_cur[Q-2:0], ge_im};
                x_re_reg[s] <= x_re_cur;
                x_im_reg[s] <= x_im_cur;
                d_reg[s]    <= d_cur;
            end
        end
    end

    assign ctl_out  = ctl_reg[Q-1];
    assign pass_out = pass_reg[Q-1];
    assign q_re     = q_re_reg[Q-1];
    assign q_im     = q_im_reg[Q-1];

endmodule

`default_nettype wire

/* dv/testbench.sv */
// testbench: self-checking bench for complex_arith_unit on the valid/stall channels.
// Directed table, then random traffic, checked against an in-bench Q16.16 predictor.
// Depends on cau_pkg and the complex_arith_unit RTL.
`timescale 1ns / 1ps

module testbench
    import cau_pkg::*;
();

    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam logic [31:0] W_MAX = 32'h7fff_ffff;
    localparam logic [31:0] W_MIN = 32'h8000_0000;
    localparam logic [31:0] W_ONE = 32'h0001_0000;
    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               eq;
        logic [1:0]         st;
    } cplx_result_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] ar;
        logic [31:0] ai;
        logic [31:0] br;
        logic [31:0] bi;
        logic        typed;
        cplx_result_t res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] mode = MODE_ADD;
    logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] r_re, r_im;
    logic equal;
    logic [1:0] status;

    cplx_result_t pending_results[$];
    int error_count = 0;
    int cycle_count = 0;
    int hold_cycles = 0;
    bit quiet = 1'b0;

    complex_arith_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .out_valid(out_valid), .out_stall(out_stall),
        .r_re(r_re), .r_im(r_im), .equal(equal), .status(status)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Clamp an exact value to the signed word range
    function automatic logic signed [31:0] clamp_word(input logic signed [127:0] v,
                                                      inout bit sat);
        if (v > $signed({96'd0, W_MAX}))
        begin
            sat = 1'b1;
            return W_MAX;
        end
        if (v < -$signed({96'd0, W_MAX}) - 1)
        begin
            sat = 1'b1;
            return W_MIN;
        end
        return v[31:0];
    endfunction

    // Quotient num * 2^16 / den truncated toward zero, then clamped
    function automatic logic signed [31:0] div_trunc(input logic signed [127:0] num,
                                                     input logic [127:0] den,
                                                     inout bit sat);
        logic [127:0] m;
        logic [127:0] q;
        m = (num < 0) ? -num : num;
        q = (m << 16) / den;
        return clamp_word((num < 0) ? -$signed(q) : $signed(q), sat);
    endfunction

    function automatic cplx_result_t predict_cplx(input logic [2:0] op,
                                                  input logic signed [31:0] ar, ai, br, bi);
        logic signed [127:0] xr, xi, yr, yi, s, den;
        cplx_result_t res;
        bit sat;
        xr = ar;
        xi = ai;
        yr = br;
        yi = bi;
        sat = 1'b0;
        res = '0;
        res.eq = (ar == br) && (ai == bi);
        case (op)
            MODE_ADD:
            begin
                res.re = clamp_word(xr + yr, sat);
                res.im = clamp_word(xi + yi, sat);
            end
            MODE_SUB:
            begin
                res.re = clamp_word(xr - yr, sat);
                res.im = clamp_word(xi - yi, sat);
            end
            MODE_MUL:
            begin
                s = xr * yr - xi * yi;
                res.re = clamp_word(s >>> 16, sat);
                s = xr * yi + xi * yr;
                res.im = clamp_word(s >>> 16, sat);
            end
            MODE_DIV:
            begin
                den = yr * yr + yi * yi;
                if (den == 0)
                begin
                    res.st = ST_DZ;
                    return res;
                end
                res.re = div_trunc(xr * yr + xi * yi, den, sat);
                res.im = div_trunc(xi * yr - xr * yi, den, sat);
            end
            MODE_NEG:
            begin
                res.re = clamp_word(-xr, sat);
                res.im = clamp_word(-xi, sat);
            end
            default: ;
        endcase
        res.st = sat ? ST_SAT : ST_OK;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] rand_part();
        case ($urandom_range(5))
            0: return W_MAX;
            1: return W_MIN;
            2: return $urandom_range(1) ? W_ONE : 32'd0;
            3: return $signed($urandom_range(2097151)) - 32'sd1048576;
            default: return $urandom;
        endcase
    endfunction

    stim_row_t dir_rows[19] = '{
        '{MODE_ADD, 0, 0, 0, 0, 1'b1, '{0, 0, 1'b1, ST_OK}},
        '{MODE_ADD, W_MAX, 0, W_ONE, 0, 1'b1, '{W_MAX, 0, 1'b0, ST_SAT}},
        '{MODE_SUB, W_MIN, 0, W_ONE, 0, 1'b1, '{W_MIN, 0, 1'b0, ST_SAT}},
        '{MODE_NEG, W_MIN, W_MIN, 0, 0, 1'b1, '{W_MAX, W_MAX, 1'b0, ST_SAT}},
        '{MODE_NEG, W_ONE, -W_ONE, 0, 0, 1'b0, '0},
        '{MODE_DIV, W_ONE, W_ONE, 0, 0, 1'b1, '{0, 0, 1'b0, ST_DZ}},
        '{MODE_SPARE5, W_ONE, 2, W_ONE, 2, 1'b1, '{0, 0, 1'b1, ST_OK}},
        '{MODE_MUL, 2 * W_ONE, 3 * W_ONE, -W_ONE, 5, 1'b0, '0},
        '{MODE_MUL, W_MAX, W_MAX, W_MAX, W_MAX, 1'b0, '0},
        '{MODE_MUL, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0, '0},
        '{MODE_MUL, -1, 0, 1, 0, 1'b0, '0},
        '{MODE_DIV, W_ONE, 0, W_ONE, 0, 1'b0, '0},
        '{MODE_DIV, W_MIN, W_MIN, 1, 0, 1'b0, '0},
        '{MODE_DIV, W_MIN, W_MAX, W_MIN, W_MIN, 1'b0, '0},
        '{MODE_DIV, 1, 0, W_MAX, W_MAX, 1'b0, '0},
        '{MODE_SUB, W_MAX, W_MAX, W_MAX, W_MAX, 1'b1, '{0, 0, 1'b1, ST_OK}},
        '{MODE_ADD, W_MIN, W_MIN, W_MIN, W_MIN, 1'b1, '{W_MIN, W_MIN, 1'b1, ST_SAT}},
        '{MODE_SPARE7, W_MAX, W_MIN, 0, 0, 1'b1, '{0, 0, 1'b0, ST_OK}},
        '{MODE_DIV, -W_ONE, 0, 3 * W_ONE, 0, 1'b0, '0}
    };

    // Offer one transaction and hold it until accepted
    task automatic send_item(input stim_row_t row);
        int gap;
        if (!quiet && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(2, 1);
            repeat (gap) @(posedge clk);
        end
        mode <= row.mode;
        a_re <= row.ar;
        a_im <= row.ai;
        b_re <= row.br;
        b_im <= row.bi;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        pending_results.push_back(row.typed ? row.res
            : predict_cplx(row.mode, row.ar, row.ai, row.br, row.bi));
    endtask

    // Stimulus: reset, directed table, random traffic, drain
    initial
    begin
        stim_row_t row;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            send_item(dir_rows[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            row = '0;
            row.mode = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                                : 3'($urandom_range(4));
            row.ar = rand_part();
            row.ai = rand_part();
            row.br = rand_part();
            row.bi = rand_part();
            if ($urandom_range(7) == 0)
            begin
                row.br = row.ar;
                row.bi = row.ai;
            end
            else if ($urandom_range(19) == 0)
            begin
                row.br = 0;
                row.bi = 0;
            end
            send_item(row);
        end
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** complex_arith_unit: PASSED **");
        else
            $display("** complex_arith_unit: FAILED **");
        $finish;
    end

    // Check each accepted result, then pick the next stall
    always @(posedge clk)
    begin
        cplx_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result at cycle %0d", cycle_count);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (r_re !== want.re) report_mismatch("r_re", r_re, want.re);
                if (r_im !== want.im) report_mismatch("r_im", r_im, want.im);
                if (equal !== want.eq) report_mismatch("equal", equal, want.eq);
                if (status !== want.st) report_mismatch("status", status, want.st);
            end
        end
        if (hold_cycles > 0)
            out_stall <= 1'b1;
        else
            out_stall <= !quiet && ($urandom_range(99) < 24);
    end

    // Count down the long receiver hold-off while the sender keeps offering
    always @(posedge clk)
    begin
        if (cycle_count == 300)
            hold_cycles <= 150;
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Count cycles, schedule the quiet stretch, enforce the limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        quiet <= (cycle_count >= 550) && (cycle_count < 850);
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("** complex_arith_unit: FAILED **");
            $finish;
        end
    end

endmodule

/* sim.f */
src/cau_pkg.sv
src/cau_mult.sv
src/cau_div.sv
src/complex_arith_unit.sv
dv/testbench.sv
